// ===== rtl/core/bcl_pkg.sv =====
package bcl_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [7:0] REFS_MAX = ~8'd0;

  typedef enum logic [1:0] {
    FN_GET     = 2'd0,
    FN_RELEASE = 2'd1,
    FN_PIN     = 2'd2,
    FN_UNPIN   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] tick;
    logic        valid;
    logic [7:0]  refs;
    logic [31:0] blk;
    logic [7:0]  dev;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/bcl_ram.sv =====
module bcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/block_buffer_cache_lru_top.sv =====
// Get: S_SCAN reads every slot in turn, then S_DRAIN and S_DONE; one read of the
//   entry memory per cycle walks every slot for the tag match and the oldest free entry.
// Release, pin, unpin: one read, at most one write-back; an out-of-range slot skips both.
// One item in flight; the next item is taken the cycle after the result enters the output
//   register; while the output stalls, the result waits in S_DONE.
// Reset (async, active low) idles the sequencer and clears the per-entry written bits;
//   an entry never written reads as all zero, so no clearing pass runs.
module block_buffer_cache_lru_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // dev[7:0], block_number[39:8], slot[44:40], now_tick[76:45], zero fill
  input  logic [bcl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [bcl_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // entry_slot[4:0], hit[5], needs_fill[6], refs_after[14:7], status[16:15], zero fill
  output logic [bcl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import bcl_pkg::*;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       nf;
    logic [7:0] refs;
    status_e    status;
  } res_t;

  state_e state_q, state_d;

  func_e       op_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [4:0]  slot_q;
  logic [31:0] now_q;
  logic        slot_ok_q;

  logic [IDX_W-1:0] scan_idx_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic             hit_q;
  logic [IDX_W-1:0] hidx_q;
  entry_t           hent_q;
  logic             free_q;
  logic [IDX_W-1:0] fidx_q;
  logic [31:0]      ftick_q;

  logic [ENTRIES-1:0] written_q;

  logic            out_vld_q;
  res_t            out_q;

  logic             in_acc;
  logic             in_get;
  logic             in_slot_ok;
  logic             scan_last;
  logic             out_free;
  logic             ram_re;
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           ent;

  logic             cmp_wr;
  logic [IDX_W-1:0] cmp_idx;
  entry_t           cmp_ent;
  res_t             cmp_res;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_get     = func_e'(s_axis_tuser) == FN_GET;
  assign in_slot_ok = 32'(s_axis_tdata[44:40]) < ENTRIES;
  assign scan_last  = (op_q != FN_GET) || (32'(scan_idx_q) == ENTRIES - 1);
  assign out_free   = !out_vld_q || m_axis_tready;
  assign ent        = written_q[rd_idx_q] ? entry_t'(ram_rdata) : '0;

  bcl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmp_idx),
    .wdata_i(cmp_ent),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_get || in_slot_ok) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = scan_idx_q;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_SCAN:  ram_re = 1'b1;
      S_DRAIN: ;
      S_DONE:  ram_we = cmp_wr && out_free;
      default: ;
    endcase
  end

  // outcome of the item from the captured entries
  always_comb begin
    cmp_wr  = 1'b0;
    cmp_idx = hidx_q;
    cmp_ent = hent_q;
    cmp_res = '{slot: slot_q, hit: 1'b0, nf: 1'b0, refs: 8'd0, status: ST_OK};
    if (op_q == FN_GET) begin
      if (hit_q) begin
        cmp_res.slot = 5'(hidx_q);
        cmp_res.hit  = 1'b1;
        if (hent_q.refs == REFS_MAX) begin
          cmp_res.refs   = REFS_MAX;
          cmp_res.status = ST_OVER;
        end else begin
          cmp_wr         = 1'b1;
          cmp_ent.refs   = hent_q.refs + 8'd1;
          cmp_ent.valid  = 1'b1;
          cmp_res.nf     = !hent_q.valid;
          cmp_res.refs   = hent_q.refs + 8'd1;
        end
      end else if (free_q) begin
        cmp_wr         = 1'b1;
        cmp_idx        = fidx_q;
        cmp_ent        = '{tick: ftick_q, valid: 1'b1, refs: 8'd1, blk: blk_q, dev: dev_q};
        cmp_res.slot   = 5'(fidx_q);
        cmp_res.nf     = 1'b1;
        cmp_res.refs   = 8'd1;
      end else begin
        cmp_res.slot   = 5'd0;
        cmp_res.status = ST_NOFREE;
      end
    end else if (slot_ok_q) begin
      cmp_idx = IDX_W'(slot_q);
      if (op_q == FN_PIN) begin
        if (hent_q.refs == REFS_MAX) begin
          cmp_res.refs   = REFS_MAX;
          cmp_res.status = ST_OVER;
        end else begin
          cmp_wr       = 1'b1;
          cmp_ent.refs = hent_q.refs + 8'd1;
          cmp_res.refs = hent_q.refs + 8'd1;
        end
      end else begin
        if (hent_q.refs == 8'd0) begin
          cmp_res.status = ST_UNDER;
        end else begin
          cmp_wr       = 1'b1;
          cmp_ent.refs = hent_q.refs - 8'd1;
          cmp_res.refs = hent_q.refs - 8'd1;
          // final release stamps the tick; unpin to zero does not
          if (op_q == FN_RELEASE && hent_q.refs == 8'd1) begin
            cmp_ent.tick = now_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      written_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re;
      rd_idx_q <= scan_idx_q;

      if (in_acc) begin
        scan_idx_q <= in_get ? '0 : IDX_W'(s_axis_tdata[44:40]);
        hit_q      <= 1'b0;
        free_q     <= 1'b0;
      end else if (state_q == S_SCAN && !scan_last) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end

      if (rd_vld_q) begin
        if (op_q == FN_GET) begin
          // lowest matching slot wins; valid bit is not part of the match
          if (!hit_q && ent.dev == dev_q && ent.blk == blk_q) begin
            hit_q <= 1'b1;
          end
          if (ent.refs == 8'd0 && (!free_q || ent.tick < ftick_q)) begin
            free_q <= 1'b1;
          end
        end else begin
          hit_q <= 1'b1;
        end
      end

      if (ram_we) begin
        written_q[cmp_idx] <= 1'b1;
      end

      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= func_e'(s_axis_tuser);
      dev_q     <= s_axis_tdata[7:0];
      blk_q     <= s_axis_tdata[39:8];
      slot_q    <= s_axis_tdata[44:40];
      now_q     <= s_axis_tdata[76:45];
      slot_ok_q <= in_slot_ok;
    end
    if (rd_vld_q) begin
      if (op_q == FN_GET) begin
        if (!hit_q && ent.dev == dev_q && ent.blk == blk_q) begin
          hidx_q <= rd_idx_q;
          hent_q <= ent;
        end
        if (ent.refs == 8'd0 && (!free_q || ent.tick < ftick_q)) begin
          fidx_q  <= rd_idx_q;
          ftick_q <= ent.tick;
        end
      end else begin
        hent_q <= ent;
      end
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= cmp_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.status, out_q.refs, out_q.nf, out_q.hit, out_q.slot};

  a_we_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_DONE)
    else $error("entry write outside completion");

  a_get_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_get |=> state_q == S_SCAN && scan_idx_q == '0)
    else $error("get did not start scan at slot zero");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> 32'(scan_idx_q) < ENTRIES)
    else $error("scan index out of range");

  a_rose_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
    else $error("result without completion");

  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> written_q[$past(cmp_idx)])
    else $error("written bit not set after write");

endmodule

// ===== bench/block_buffer_cache_lru_top_tb.sv =====
`timescale 1ns / 100ps

module block_buffer_cache_lru_top_tb;
  import bcl_pkg::*;

  localparam int HOLD_AT       = 60;   // result count at which the sink stalls for long
  localparam int HOLD_CYCLES   = 400;
  localparam int MIXED_ITEMS   = 80;
  localparam int ROUNDS        = 3;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    func_e       func;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  slot;
    logic [31:0] tick;
  } req_t;

  // lowest field last, so the struct maps straight onto m_axis_tdata
  typedef struct packed {
    status_e     status;
    logic [7:0]  refs;
    logic        fill;
    logic        hit;
    logic [4:0]  slot;
  } grant_t;

  typedef struct packed {
    req_t   req;
    logic   typed;
    grant_t want;   // status, refs, fill, hit, slot
  } row_t;

  localparam int NROWS = 17;
  localparam row_t PLAN [NROWS] = '{
    '{'{FN_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0000_0000}, 1'b1,
      '{ST_OK,    8'd1, 1'b1, 1'b1, 5'd0}},
    '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd5,  32'h0000_0000}, 1'b1,
      '{ST_UNDER, 8'd0, 1'b0, 1'b0, 5'd5}},
    '{'{FN_UNPIN,   8'hff, 32'hffff_ffff, 5'd31, 32'hffff_ffff}, 1'b1,
      '{ST_UNDER, 8'd0, 1'b0, 1'b0, 5'd31}},
    '{'{FN_GET,     8'hff, 32'hffff_ffff, 5'd31, 32'hffff_ffff}, 1'b1,
      '{ST_OK,    8'd1, 1'b1, 1'b0, 5'd1}},
    '{'{FN_PIN,     8'h00, 32'h0000_0000, 5'd1,  32'h0000_0000}, 1'b1,
      '{ST_OK,    8'd2, 1'b0, 1'b0, 5'd1}},
    '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'hffff_ffff}, 1'b1,
      '{ST_OK,    8'd0, 1'b0, 1'b0, 5'd0}},
    '{'{FN_UNPIN,   8'h00, 32'h0000_0000, 5'd1,  32'h0000_0000}, 1'b1,
      '{ST_OK,    8'd1, 1'b0, 1'b0, 5'd1}},
    '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd1,  32'h0000_0001}, 1'b1,
      '{ST_OK,    8'd0, 1'b0, 1'b0, 5'd1}},
    '{'{FN_GET,     8'hff, 32'hffff_ffff, 5'd0,  32'h0000_0000}, 1'b1,
      '{ST_OK,    8'd1, 1'b0, 1'b1, 5'd1}},
    '{'{FN_PIN,     8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000}, 1'b1,
      '{ST_OK,    8'd1, 1'b0, 1'b0, 5'd31}},
    '{'{FN_GET,     8'h55, 32'haaaa_aaaa, 5'd10, 32'h1234_5678}, 1'b0, '0},
    '{'{FN_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 32'h7fff_ffff}, 1'b0, '0},
    '{'{FN_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0000_0000}, 1'b0, '0},
    '{'{FN_RELEASE, 8'h00, 32'h0000_0000, 5'd2,  32'h8000_0000}, 1'b0, '0},
    '{'{FN_GET,     8'haa, 32'h5555_5555, 5'd21, 32'h0000_0000}, 1'b0, '0},
    '{'{FN_PIN,     8'h00, 32'h0000_0000, 5'd3,  32'h0000_0000}, 1'b0, '0},
    '{'{FN_GET,     8'h55, 32'haaaa_aaaa, 5'd0,  32'h0000_0000}, 1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // shadow of the tag store
  logic [7:0]  c_dev   [ENTRIES];
  logic [31:0] c_blk   [ENTRIES];
  logic [7:0]  c_refs  [ENTRIES];
  logic        c_valid [ENTRIES];
  logic [31:0] c_tick  [ENTRIES];

  grant_t      pending_grants[$];
  logic [31:0] tick_clock = '0;
  bit          quiet = 1'b0;
  int          n_items, n_gets, n_hits, n_nofree, n_under, n_over;
  int          n_results, n_errors, n_shown;

  always #5 clk_i = ~clk_i;

  block_buffer_cache_lru_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      c_dev[i] = '0;
      c_blk[i] = '0;
      c_refs[i] = '0;
      c_valid[i] = 1'b0;
      c_tick[i] = '0;
    end
  end

  function automatic grant_t cache_step(req_t rq);
    grant_t g;
    int     pick;
    g = '0;
    g.slot = rq.slot;
    if (rq.func == FN_GET) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (c_dev[i] == rq.dev && c_blk[i] == rq.blk) begin
          g.slot = 5'(i);
          g.hit = 1'b1;
          if (c_refs[i] == REFS_MAX) begin
            g.refs = REFS_MAX;
            g.status = ST_OVER;
            return g;
          end
          g.fill = ~c_valid[i];
          c_refs[i] = c_refs[i] + 8'd1;
          c_valid[i] = 1'b1;
          g.refs = c_refs[i];
          return g;
        end
      end
      // oldest release among idle entries, lowest slot on ties
      pick = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (c_refs[i] == 8'd0 && (pick < 0 || c_tick[i] < c_tick[pick])) pick = i;
      if (pick < 0) begin
        g = '0;
        g.status = ST_NOFREE;
        return g;
      end
      c_dev[pick] = rq.dev;
      c_blk[pick] = rq.blk;
      c_refs[pick] = 8'd1;
      c_valid[pick] = 1'b1;
      g.slot = 5'(pick);
      g.fill = 1'b1;
      g.refs = 8'd1;
      return g;
    end
    if (rq.slot >= ENTRIES) return g;
    if (rq.func == FN_PIN) begin
      if (c_refs[rq.slot] == REFS_MAX) begin
        g.refs = REFS_MAX;
        g.status = ST_OVER;
        return g;
      end
      c_refs[rq.slot] = c_refs[rq.slot] + 8'd1;
      g.refs = c_refs[rq.slot];
      return g;
    end
    if (c_refs[rq.slot] == 8'd0) begin
      g.status = ST_UNDER;
      return g;
    end
    c_refs[rq.slot] = c_refs[rq.slot] - 8'd1;
    // only a release stamps the tick; unpin to zero leaves it
    if (rq.func == FN_RELEASE && c_refs[rq.slot] == 8'd0) c_tick[rq.slot] = rq.tick;
    g.refs = c_refs[rq.slot];
    return g;
  endfunction

  function automatic logic [31:0] next_tick();
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return 32'($urandom_range(2, 0));   // ties
      2: return 32'hffff_ffff;
      default: begin
        tick_clock = tick_clock + 32'($urandom_range(100, 1));
        return tick_clock;
      end
    endcase
  endfunction

  function automatic req_t fresh_get();
    req_t rq;
    rq.func = FN_GET;
    rq.dev = 8'($urandom_range(255, 0));
    rq.blk = $urandom();
    rq.slot = 5'($urandom_range(31, 0));
    rq.tick = $urandom();
    return rq;
  endfunction

  function automatic int busy_slot();
    int base;
    base = $urandom_range(ENTRIES - 1, 0);
    for (int k = 0; k < ENTRIES; k++)
      if (c_refs[(base + k) % ENTRIES] != 8'd0) return (base + k) % ENTRIES;
    return -1;
  endfunction

  function automatic int free_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (c_refs[i] == 8'd0) n++;
    return n;
  endfunction

  function automatic req_t mixed_req();
    req_t rq;
    int   r;
    int   t;
    int   busy;
    rq = fresh_get();
    rq.func = func_e'($urandom_range(3, 0));
    rq.tick = next_tick();
    r = $urandom_range(99, 0);
    if (r < 25) return rq;   // plain noise
    if (r < 60) begin
      rq.func = FN_GET;
      if ($urandom_range(1, 0) == 1) begin
        t = $urandom_range(ENTRIES - 1, 0);
        rq.dev = c_dev[t];
        rq.blk = c_blk[t];
      end
      return rq;
    end
    rq.func = (r < 80) ? FN_RELEASE : ((r < 88) ? FN_PIN : FN_UNPIN);
    busy = busy_slot();
    if (busy >= 0 && $urandom_range(4, 0) != 0) rq.slot = 5'(busy);
    return rq;
  endfunction

  task automatic send_req(input req_t rq, output grant_t pred);
    int gap;
    gap = quiet ? 0 : $urandom_range(15, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, rq.tick, rq.slot, rq.blk, rq.dev};
    s_axis_tuser <= rq.func;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = cache_step(rq);
    pending_grants.push_back(pred);
    n_items++;
    if (rq.func == FN_GET) n_gets++;
  endtask

  task automatic run_burst();
    req_t   rq;
    grant_t g;
    int     s;
    int     t;
    int     base;
    int     i;
    while (free_count() > 0) begin
      send_req(fresh_get(), g);
    end
    repeat (2) send_req(fresh_get(), g);
    rq = fresh_get();
    t = $urandom_range(ENTRIES - 1, 0);
    rq.dev = c_dev[t];
    rq.blk = c_blk[t];
    send_req(rq, g);
    // the one idle entry carries the largest tick and must still be recycled
    s = $urandom_range(ENTRIES - 1, 0);
    while (c_refs[s] != 8'd0) begin
      rq = fresh_get();
      rq.func = FN_RELEASE;
      rq.slot = 5'(s);
      rq.tick = 32'hffff_ffff;
      send_req(rq, g);
    end
    send_req(fresh_get(), g);
    base = $urandom_range(ENTRIES - 1, 0);
    for (int k = 0; k < ENTRIES; k++) begin
      i = (base + k) % ENTRIES;
      while (c_refs[i] != 8'd0) begin
        rq = fresh_get();
        rq.func = ($urandom_range(3, 0) == 0) ? FN_UNPIN : FN_RELEASE;
        rq.slot = 5'(i);
        rq.tick = next_tick();
        send_req(rq, g);
      end
    end
  endtask

  // drive one entry to the count ceiling through hits and pins, then past it
  task automatic run_pump();
    req_t   tag;
    req_t   rq;
    grant_t g;
    int     k;
    tag = fresh_get();
    send_req(tag, g);
    k = g.slot;
    while (c_refs[k] != REFS_MAX) begin
      rq = fresh_get();
      if ($urandom_range(1, 0) == 1) begin
        rq.dev = tag.dev;
        rq.blk = tag.blk;
      end else begin
        rq.func = FN_PIN;
        rq.slot = 5'(k);
      end
      send_req(rq, g);
    end
    rq = fresh_get();
    rq.func = FN_PIN;
    rq.slot = 5'(k);
    send_req(rq, g);
    send_req(tag, g);
    rq.func = FN_UNPIN;
    send_req(rq, g);
    rq.func = FN_RELEASE;
    send_req(rq, g);
  endtask

  initial begin : stimulus
    grant_t g;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NROWS; i++) begin
      send_req(PLAN[i].req, g);
      if (PLAN[i].typed) pending_grants[pending_grants.size() - 1] = PLAN[i].want;
    end
    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      quiet = (rnd == 1);
      repeat (MIXED_ITEMS) begin
        send_req(mixed_req(), g);
      end
      quiet = 1'b0;
      run_burst();
    end
    quiet = 1'b1;
    run_pump();
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d items, %0d of them gets with %0d hits;", n_items, n_gets, n_hits);
    $display("results: %0d no free entry, %0d underflow, %0d overflow, %0d mismatches",
             n_nofree, n_under, n_over, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : sink
    int     stall;
    grant_t got;
    grant_t want;
    @(posedge rst_ni);
    forever begin
      stall = (n_results == HOLD_AT) ? HOLD_CYCLES : (quiet ? 0 : $urandom_range(15, 0));
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = grant_t'(m_axis_tdata[$bits(grant_t)-1:0]);
      n_results++;
      if (pending_grants.size() == 0) begin
        n_errors++;
        if (n_shown < 10) begin
          n_shown++;
          $display("unexpected item on output: tdata %h", m_axis_tdata);
        end
      end else begin
        want = pending_grants.pop_front();
        if (want.hit) n_hits++;
        case (want.status)
          ST_NOFREE: n_nofree++;
          ST_UNDER:  n_under++;
          ST_OVER:   n_over++;
          default: ;
        endcase
        if (got.slot !== want.slot || got.hit !== want.hit || got.fill !== want.fill ||
            got.refs !== want.refs || got.status !== want.status ||
            m_axis_tdata[OUT_DATA_W-1:$bits(grant_t)] !== '0) begin
          n_errors++;
          if (n_shown < 10) begin
            n_shown++;
            $display("result %0d: want slot %0d hit %0d fill %0d refs %0d status %0d",
                     n_results, want.slot, want.hit, want.fill, want.refs, want.status);
            $display("result %0d:  got slot %0d hit %0d fill %0d refs %0d status %0d",
                     n_results, got.slot, got.hit, got.fill, got.refs, got.status);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_grants.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== block_buffer_cache_lru_top.f =====
rtl/core/bcl_pkg.sv
rtl/core/bcl_ram.sv
rtl/core/block_buffer_cache_lru_top.sv
bench/block_buffer_cache_lru_top_tb.sv
